### sv/bru_pkg.sv
// Shared types, constants and helper functions of the bearing and range unit.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package bru_pkg;

  localparam int COORD_W = 16;
  localparam int ANG_W = 16;
  localparam int DIST_W = 17;
  localparam int DIFF_W = 17;
  localparam int SQR_W = 34;
  localparam int XY_W = 36;
  localparam int Z_W = 32;
  localparam int SQ_W = 35;
  localparam int WRAP_W = 19;
  localparam int CMD_W = 2;

  localparam int DEF_CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int SQRT_STEPS = 17;

  localparam int PI_Q = 25736;
  localparam int TWO_PI_Q = 51472;
  localparam int PI_Q28 = 843314857;
  localparam int XY_SCALE_SHIFT = 16;
  localparam int Z_ROUND_HALF = 16384;
  localparam int Z_ROUND_SHIFT = 15;

  localparam logic [CMD_W-1:0] CMD_BEARING = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DISTANCE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_IMAGE = 2'd2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_IDX_MIRROR = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [ANG_W-1:0] heading;
    logic signed [ANG_W-1:0] ang2;
    logic                    inv2;
    logic                    zero;
  } side_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [SQ_W-1:0]        n;
    logic [SQ_W-1:0]        r;
    side_t                  side;
  } cell_data_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] angle;
    logic [DIST_W-1:0]       distance;
    logic                    inv;
  } result_t;

  function automatic logic signed [Z_W-1:0] atan_q28(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0: v = 32'sd210828714;
      1: v = 32'sd124459457;
      2: v = 32'sd65760959;
      3: v = 32'sd33381290;
      4: v = 32'sd16755422;
      5: v = 32'sd8385879;
      6: v = 32'sd4193963;
      7: v = 32'sd2097109;
      8: v = 32'sd1048571;
      9: v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

  // One correction by a full turn brings a difference back toward [-pi, pi].
  function automatic logic signed [WRAP_W-1:0] wrap_angle(input logic signed [WRAP_W-1:0] d);
    logic signed [WRAP_W-1:0] w;
    if (d > WRAP_W'(PI_Q)) begin
      w = d - WRAP_W'(TWO_PI_Q);
    end else if (d < -WRAP_W'(PI_Q)) begin
      w = d + WRAP_W'(TWO_PI_Q);
    end else begin
      w = d;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

### sv/bru_front.sv
// Input stages of the bearing and range unit: differences, squares, sum,
// CORDIC half-plane setup and the image angle conversion.
// Depends on bru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bru_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                en,
  input  wire logic                                in_vld,
  input  wire logic [bru_pkg::CMD_W-1:0]           command,
  input  wire logic signed [bru_pkg::COORD_W-1:0]  ref_x,
  input  wire logic signed [bru_pkg::COORD_W-1:0]  ref_y,
  input  wire logic signed [bru_pkg::COORD_W-1:0]  point_x,
  input  wire logic signed [bru_pkg::COORD_W-1:0]  point_y,
  input  wire logic signed [bru_pkg::ANG_W-1:0]    heading,
  input  wire logic signed [bru_pkg::ANG_W-1:0]    mirror,
  output logic                                     out_vld,
  output bru_pkg::cell_data_t                      out_data
);
  import bru_pkg::*;

  logic signed [DIFF_W-1:0] dx_nxt, dy_nxt;
  logic                     inv_nxt;
  logic signed [DIFF_W-1:0] hd_neg;
  logic signed [WRAP_W-1:0] img_wrap;
  logic signed [ANG_W-1:0]  ang2_nxt;

  logic                     s1_vld_r;
  logic [CMD_W-1:0]         s1_cmd_r;
  logic signed [DIFF_W-1:0] s1_dx_r, s1_dy_r;
  logic signed [ANG_W-1:0]  s1_hd_r, s1_ang2_r;
  logic                     s1_inv2_r;

  logic signed [SQR_W-1:0]  dxx_nxt, dyy_nxt;
  logic signed [XY_W-1:0]   dxe, dye, x_nxt, y_nxt;
  logic signed [Z_W-1:0]    z_nxt;
  side_t                    side_nxt;

  logic                     s2_vld_r;
  logic [SQR_W-1:0]         s2_dxx_r, s2_dyy_r;
  logic signed [XY_W-1:0]   s2_x_r, s2_y_r;
  logic signed [Z_W-1:0]    s2_z_r;
  side_t                    s2_side_r;

  logic                     s3_vld_r;
  cell_data_t               s3_data_r, s3_data_nxt;

  always_comb begin
    dx_nxt = DIFF_W'(point_x) - DIFF_W'(ref_x);
    dy_nxt = DIFF_W'(point_y) - DIFF_W'(ref_y);
    inv_nxt = (heading > ANG_W'(PI_Q)) || (heading < -ANG_W'(PI_Q));
    hd_neg = (heading == ANG_W'(PI_Q)) ? DIFF_W'(PI_Q) : -DIFF_W'(heading);
    img_wrap = wrap_angle(WRAP_W'(hd_neg) + WRAP_W'(mirror));
    ang2_nxt = inv_nxt ? '0 : img_wrap[ANG_W-1:0];
  end

  always_comb begin
    dxx_nxt = SQR_W'(s1_dx_r) * SQR_W'(s1_dx_r);
    dyy_nxt = SQR_W'(s1_dy_r) * SQR_W'(s1_dy_r);
    dxe = XY_W'(s1_dx_r) <<< XY_SCALE_SHIFT;
    dye = XY_W'(s1_dy_r) <<< XY_SCALE_SHIFT;
    if (s1_dx_r < 0) begin
      x_nxt = -dxe;
      y_nxt = -dye;
      z_nxt = (s1_dy_r >= 0) ? Z_W'(PI_Q28) : -Z_W'(PI_Q28);
    end else begin
      x_nxt = dxe;
      y_nxt = dye;
      z_nxt = '0;
    end
    side_nxt.cmd = s1_cmd_r;
    side_nxt.heading = s1_hd_r;
    side_nxt.ang2 = s1_ang2_r;
    side_nxt.inv2 = s1_inv2_r;
    side_nxt.zero = (s1_dx_r == 0) && (s1_dy_r == 0);
  end

  always_comb begin
    s3_data_nxt.x = s2_x_r;
    s3_data_nxt.y = s2_y_r;
    s3_data_nxt.z = s2_z_r;
    s3_data_nxt.n = SQ_W'(s2_dxx_r) + SQ_W'(s2_dyy_r);
    s3_data_nxt.r = '0;
    s3_data_nxt.side = s2_side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r <= command;
      s1_dx_r <= dx_nxt;
      s1_dy_r <= dy_nxt;
      s1_hd_r <= heading;
      s1_ang2_r <= ang2_nxt;
      s1_inv2_r <= inv_nxt;
      s2_dxx_r <= dxx_nxt;
      s2_dyy_r <= dyy_nxt;
      s2_x_r <= x_nxt;
      s2_y_r <= y_nxt;
      s2_z_r <= z_nxt;
      s2_side_r <= side_nxt;
      s3_data_r <= s3_data_nxt;
    end
  end

  assign out_vld = s3_vld_r;
  assign out_data = s3_data_r;

endmodule

`default_nettype wire

### sv/bru_cell.sv
// One cell of the chain: a CORDIC vectoring iteration and one square root digit (each
// only where STAGE is in its range), registered and handed to the next cell. Depends on bru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bru_cell #(
  parameter int STAGE = 0,
  parameter int CORDIC_STAGES = bru_pkg::DEF_CORDIC_STAGES
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire bru_pkg::cell_data_t in_data,
  output logic                     out_vld,
  output bru_pkg::cell_data_t      out_data
);
  import bru_pkg::*;

  localparam bit DO_CORDIC = STAGE < CORDIC_STAGES;
  localparam bit DO_SQRT = STAGE < SQRT_STEPS;
  localparam int SQ_M = DO_SQRT ? (SQRT_STEPS - 1 - STAGE) : 0;
  localparam logic signed [Z_W-1:0] ATAN_K = atan_q28(STAGE);
  localparam logic [SQ_W-1:0] SQ_BIT = SQ_W'(1) << (2 * SQ_M);

  logic signed [XY_W-1:0] x, y, xs, ys;
  logic signed [Z_W-1:0]  z;
  logic [SQ_W-1:0]        trial;
  cell_data_t             data_nxt;
  logic                   vld_r;
  cell_data_t             data_r;

  always_comb begin
    x = in_data.x;
    y = in_data.y;
    z = in_data.z;
    xs = x >>> STAGE;
    ys = y >>> STAGE;
    trial = in_data.r + SQ_BIT;
    data_nxt = in_data;
    if (DO_CORDIC) begin
      if (y >= 0) begin
        data_nxt.x = x + ys;
        data_nxt.y = y - xs;
        data_nxt.z = z + ATAN_K;
      end else begin
        data_nxt.x = x - ys;
        data_nxt.y = y + xs;
        data_nxt.z = z - ATAN_K;
      end
    end
    if (DO_SQRT) begin
      if (in_data.n >= trial) begin
        data_nxt.n = in_data.n - trial;
        data_nxt.r = (in_data.r >> 1) + SQ_BIT;
      end else begin
        data_nxt.r = in_data.r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_data = data_r;

endmodule

`default_nettype wire

### sv/bru_back.sv
// Output stages: rounds the CORDIC angle, rounds the root, applies the
// heading difference and selects the result fields. Depends on bru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bru_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire bru_pkg::cell_data_t in_data,
  output logic                     out_vld,
  output bru_pkg::result_t         out_res
);
  import bru_pkg::*;

  localparam int ZR_W = Z_W + 1;

  logic signed [ZR_W-1:0]   z_round;
  logic signed [WRAP_W-1:0] z_q13;
  logic signed [ANG_W-1:0]  angle_nxt;
  logic [DIST_W-1:0]        dist_nxt;

  logic                     b1_vld_r;
  logic signed [ANG_W-1:0]  b1_angle_r;
  logic [DIST_W-1:0]        b1_dist_r;
  side_t                    b1_side_r;

  logic signed [WRAP_W-1:0] ae, ge, a_abs, g_abs, s1, s2, d, dw;
  logic                     a_neg, g_neg;

  always_comb begin
    z_round = (ZR_W'(in_data.z) + ZR_W'(Z_ROUND_HALF)) >>> Z_ROUND_SHIFT;
    z_q13 = z_round[WRAP_W-1:0];
    if (in_data.side.zero) begin
      angle_nxt = '0;
    end else if (z_q13 > WRAP_W'(PI_Q)) begin
      angle_nxt = ANG_W'(PI_Q);
    end else if (z_q13 < -WRAP_W'(PI_Q)) begin
      angle_nxt = -ANG_W'(PI_Q);
    end else begin
      angle_nxt = z_q13[ANG_W-1:0];
    end
    dist_nxt = in_data.r[DIST_W-1:0] + DIST_W'(in_data.n > in_data.r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_vld_r <= 1'b0;
    end else if (en) begin
      b1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_angle_r <= angle_nxt;
      b1_dist_r <= dist_nxt;
      b1_side_r <= in_data.side;
    end
  end

  always_comb begin
    ae = WRAP_W'(b1_angle_r);
    ge = WRAP_W'(b1_side_r.heading);
    a_neg = b1_angle_r[ANG_W-1];
    g_neg = b1_side_r.heading[ANG_W-1];
    a_abs = a_neg ? -ae : ae;
    g_abs = g_neg ? -ge : ge;
    s1 = a_abs + g_abs;
    s2 = WRAP_W'(TWO_PI_Q) - s1;
    if (a_neg == g_neg) begin
      d = ae - ge;
    end else if (s1 < s2) begin
      d = g_neg ? s1 : -s1;
    end else begin
      d = g_neg ? -s2 : s2;
    end
    dw = wrap_angle(d);

    out_res = '0;
    case (b1_side_r.cmd)
      CMD_BEARING: begin
        out_res.angle = dw[ANG_W-1:0];
      end
      CMD_DISTANCE: begin
        out_res.distance = b1_dist_r;
      end
      CMD_IMAGE: begin
        out_res.angle = b1_side_r.ang2;
        out_res.inv = b1_side_r.inv2;
      end
      default: begin
        out_res = '0;
      end
    endcase
  end

  assign out_vld = b1_vld_r;

endmodule

`default_nettype wire

### sv/bearing_and_range_unit.sv
// Bearing and range unit: atan2 bearing with heading difference, rounded
// distance and image angle conversion through a chain of CORDIC/root cells.
// Stages: the front stages, the chain of CORDIC/root cells, the back stage and the output register.
// Throughput: one item per cycle through the fully pipelined cell chain while the skid register is empty.
// Reset (synchronous, rst_n low) empties the pipeline and sets the mirror
// orientation register to 0.
`timescale 1ns / 1ps
`default_nettype none

module bearing_and_range_unit #(
  parameter int CORDIC_STAGES = bru_pkg::DEF_CORDIC_STAGES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [bru_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [bru_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [bru_pkg::CFG_DATA_W-1:0]         cfg_prdata,
  output logic                                   cfg_pready,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // ref_x[15:0], ref_y[31:16], point_x[47:32], point_y[63:48], heading[79:64]
  input  wire logic [79:0]                       in_tdata,
  // command[1:0]
  input  wire logic [1:0]                        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // angle_out[15:0], distance_out[32:16], zero[39:33]
  output logic [39:0]                            out_tdata,
  // invalid[0]
  output logic [0:0]                             out_tuser
);
  import bru_pkg::*;

  localparam int CHAIN_LEN = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

  logic signed [ANG_W-1:0] mirror_r, mirror_nxt;
  logic                    cfg_wr;
  logic                    pipe_en;

  logic                    chain_vld [CHAIN_LEN+1];
  cell_data_t              chain_data [CHAIN_LEN+1];

  logic                    back_vld;
  result_t                 back_res;

  logic                    out_vld_r, out_vld_nxt;
  result_t                 out_r, out_nxt;
  logic                    skid_vld_r, skid_vld_nxt;
  result_t                 skid_r, skid_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    mirror_nxt = mirror_r;
    if (cfg_wr && (cfg_paddr[2] == REG_IDX_MIRROR)) begin
      mirror_nxt = cfg_pwdata[ANG_W-1:0];
    end
    if (cfg_paddr[2] == REG_IDX_MIRROR) begin
      cfg_prdata = CFG_DATA_W'(mirror_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= '0;
    end else begin
      mirror_r <= mirror_nxt;
    end
  end

  assign pipe_en = !skid_vld_r;
  assign in_tready = pipe_en;

  bru_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (in_tvalid),
    .command  (in_tuser),
    .ref_x    (in_tdata[15:0]),
    .ref_y    (in_tdata[31:16]),
    .point_x  (in_tdata[47:32]),
    .point_y  (in_tdata[63:48]),
    .heading  (in_tdata[79:64]),
    .mirror   (mirror_r),
    .out_vld  (chain_vld[0]),
    .out_data (chain_data[0])
  );

  for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
    bru_cell #(
      .STAGE         (k),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .in_vld   (chain_vld[k]),
      .in_data  (chain_data[k]),
      .out_vld  (chain_vld[k+1]),
      .out_data (chain_data[k+1])
    );
  end

  bru_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (chain_vld[CHAIN_LEN]),
    .in_data (chain_data[CHAIN_LEN]),
    .out_vld (back_vld),
    .out_res (back_res)
  );

  // The skid register catches the item that leaves the pipeline while the
  // output holds; once it is full the whole pipeline stalls.
  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt = out_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt = skid_r;
    if (out_vld_r && !out_tready) begin
      if (!skid_vld_r && back_vld) begin
        skid_vld_nxt = 1'b1;
        skid_nxt = back_res;
      end
    end else if (skid_vld_r) begin
      out_vld_nxt = 1'b1;
      out_nxt = skid_r;
      skid_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = back_vld;
      out_nxt = back_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = {7'b0, out_r.distance, out_r.angle};
  assign out_tuser = out_r.inv;

endmodule

`default_nettype wire

### test/tb_bearing_and_range_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for bearing_and_range_unit: drives bearing, distance
// and image-angle queries through the stream ports under random stalls and
// compares every result with a built-in fixed-point predictor. Needs bru_pkg.

module tb_bearing_and_range_unit;
  import bru_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CORDIC_STEPS = DEF_CORDIC_STAGES;
  localparam int LATENCY = 5 + 17;
  localparam int LIMIT_CYCLES = 300000;
  localparam int REG_MIRROR = 0;
  localparam int REG_SPARE = 1;
  localparam longint HALF_TURN_Q28 = 64'sd843314857;
  localparam longint ATAN_STEP [0:23] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963, 2097109,
    1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32
  };

  typedef struct {
    logic signed [ANG_W-1:0] angle;
    logic [DIST_W-1:0]       distance;
    logic                    inv;
  } answer_t;

  class bearing_scoreboard;
    int mirror;
    int errors;
    answer_t awaited_answers[$];

    function new();
      mirror = 0;
      errors = 0;
    endfunction

    function void set_mirror(logic [31:0] value);
      mirror = int'($signed(value[15:0]));
    endfunction

    function int pending();
      return awaited_answers.size();
    endfunction

    function int fold_turn(int d);
      if (d > PI_Q) return d - TWO_PI_Q;
      if (d < -PI_Q) return d + TWO_PI_Q;
      return d;
    endfunction

    function int cordic_bearing(int dy, int dx);
      longint x, y, z, xs, ys, r;
      if (dx == 0 && dy == 0) return 0;
      x = longint'(dx) * 65536;
      y = longint'(dy) * 65536;
      z = 0;
      if (dx < 0) begin
        x = -x;
        y = -y;
        z = (dy >= 0) ? HALF_TURN_Q28 : -HALF_TURN_Q28;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_STEP[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_STEP[i];
        end
      end
      r = (z + 16384) >>> 15;
      if (r > PI_Q) r = PI_Q;
      if (r < -PI_Q) r = -PI_Q;
      return int'(r);
    endfunction

    function int heading_difference(int a, int g);
      int d, s1, s2;
      if ((a >= 0) == (g >= 0)) begin
        d = a - g;
      end else begin
        s1 = (g < 0 ? -g : g) + (a < 0 ? -a : a);
        s2 = TWO_PI_Q - s1;
        if (s1 < s2) d = (g < 0) ? s1 : -s1;
        else d = (g >= 0) ? s2 : -s2;
      end
      return fold_turn(d);
    endfunction

    function longint unsigned round_root(longint unsigned s);
      longint unsigned r, b, n;
      r = 0;
      b = 64'd1 << 62;
      n = s;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      if (s - r * r > r) r++;
      return r;
    endfunction

    function void note_item(logic [CMD_W-1:0] cmd, logic [79:0] data);
      answer_t a;
      int rx, ry, px, py, hd;
      longint dx, dy;
      rx = int'($signed(data[15:0]));
      ry = int'($signed(data[31:16]));
      px = int'($signed(data[47:32]));
      py = int'($signed(data[63:48]));
      hd = int'($signed(data[79:64]));
      a.angle = '0;
      a.distance = '0;
      a.inv = 1'b0;
      case (cmd)
        CMD_BEARING: begin
          a.angle = ANG_W'(heading_difference(cordic_bearing(py - ry, px - rx), hd));
        end
        CMD_DISTANCE: begin
          dx = longint'(rx) - px;
          dy = longint'(ry) - py;
          a.distance = DIST_W'(round_root(longint'(dx * dx + dy * dy)));
        end
        CMD_IMAGE: begin
          if (hd > PI_Q || hd < -PI_Q) a.inv = 1'b1;
          else a.angle = ANG_W'(fold_turn(((hd == PI_Q) ? PI_Q : -hd) + mirror));
        end
        default: begin
        end
      endcase
      awaited_answers.push_back(a);
    endfunction

    function void check_result(logic [39:0] data, logic [0:0] user);
      answer_t e;
      logic signed [ANG_W-1:0] got_angle;
      logic [DIST_W-1:0] got_dist;
      got_angle = data[15:0];
      got_dist = data[32:16];
      if (awaited_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, angle %0d distance %0d invalid %0d", $time,
                 got_angle, got_dist, user[0]);
        return;
      end
      e = awaited_answers.pop_front();
      if (got_angle !== e.angle) begin
        errors++;
        $display("%0t: angle_out expected %0d actual %0d", $time, e.angle, got_angle);
      end
      if (got_dist !== e.distance) begin
        errors++;
        $display("%0t: distance_out expected %0d actual %0d", $time, e.distance, got_dist);
      end
      if (user[0] !== e.inv) begin
        errors++;
        $display("%0t: invalid expected %0d actual %0d", $time, e.inv, user[0]);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // ref_x[15:0], ref_y[31:16], point_x[47:32], point_y[63:48], heading[79:64]
  logic [79:0] in_tdata = '0;
  // command[1:0]
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b1;
  // angle_out[15:0], distance_out[32:16], zero[39:33]
  logic [39:0] out_tdata;
  // invalid[0]
  logic [0:0] out_tuser;

  bearing_scoreboard sb;
  bit calm = 1'b0;
  int cycle_count = 0;

  bearing_and_range_unit u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_item(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [CMD_W-1:0] cmd, int rx, int ry, int px, int py, int hd);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {16'(hd), 16'(py), 16'(px), 16'(ry), 16'(rx)};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(int index, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_ADDR_W'(index * 4);
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (index == REG_MIRROR) sb.set_mirror(value);
    @(posedge clk);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return -32768;
          1: return 32767;
          2: return 0;
          default: return -1;
        endcase
      end
      1, 2: return $urandom_range(0, 16) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_relative_angle();
    case ($urandom_range(0, 9))
      0: return PI_Q;
      1: return -PI_Q;
      2: return ($urandom_range(0, 1) == 0) ? PI_Q + 1 : -PI_Q - 1;
      3: return $urandom;
      default: return $urandom_range(0, 2 * PI_Q) - PI_Q;
    endcase
  endfunction

  task automatic send_random_item();
    logic [CMD_W-1:0] cmd;
    int rx, ry, px, py, hd;
    cmd = ($urandom_range(0, 19) == 0) ? CMD_UNUSED : CMD_W'($urandom_range(0, 2));
    rx = pick_coord();
    ry = pick_coord();
    if ($urandom_range(0, 2) == 0) begin
      px = rx + $urandom_range(0, 64) - 32;
      py = ry + $urandom_range(0, 64) - 32;
    end else begin
      px = pick_coord();
      py = pick_coord();
    end
    if (cmd == CMD_IMAGE) hd = pick_relative_angle();
    else if ($urandom_range(0, 2) == 0) hd = $urandom;
    else hd = $urandom_range(0, 2 * PI_Q) - PI_Q;
    send_item(cmd, rx, ry, px, py, hd);
  endtask

  initial begin
    int mirror_plan [0:5];
    sb = new();
    mirror_plan[0] = PI_Q;
    mirror_plan[1] = -PI_Q;
    mirror_plan[2] = $urandom_range(0, 2 * PI_Q) - PI_Q;
    mirror_plan[3] = $urandom_range(0, 2 * PI_Q) - PI_Q;
    mirror_plan[4] = 0;
    mirror_plan[5] = $urandom_range(0, 2 * PI_Q) - PI_Q;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_BEARING, 0, 0, 0, 0, 0);
    send_item(CMD_BEARING, 5, -7, 5, -7, 1000);
    send_item(CMD_BEARING, -32768, -32768, 32767, 32767, 32767);
    send_item(CMD_BEARING, 32767, 32767, -32768, -32768, -32768);
    send_item(CMD_BEARING, 100, 0, -100, 0, 0);
    send_item(CMD_BEARING, 0, 0, -50, -1, 0);
    send_item(CMD_BEARING, 0, 0, 0, 300, -PI_Q);
    send_item(CMD_BEARING, 0, 0, 0, -300, PI_Q);
    send_item(CMD_BEARING, 0, 0, -10, 5, -20000);
    send_item(CMD_BEARING, 0, 0, 10, -10, 30000);
    send_item(CMD_BEARING, 0, 0, -32768, 0, -32768);
    send_item(CMD_DISTANCE, -32768, -32768, 32767, 32767, 0);
    send_item(CMD_DISTANCE, 0, 0, 3, 4, 0);
    send_item(CMD_DISTANCE, 7, 7, 7, 7, 0);
    send_item(CMD_DISTANCE, 32767, -32768, -32768, 32767, 0);
    send_item(CMD_DISTANCE, 0, 0, 1, 1, 0);
    send_item(CMD_IMAGE, 0, 0, 0, 0, PI_Q);
    send_item(CMD_IMAGE, 0, 0, 0, 0, -PI_Q);
    send_item(CMD_IMAGE, 0, 0, 0, 0, PI_Q + 1);
    send_item(CMD_IMAGE, 0, 0, 0, 0, -PI_Q - 1);
    send_item(CMD_IMAGE, 0, 0, 0, 0, 32767);
    send_item(CMD_IMAGE, 0, 0, 0, 0, -32768);
    send_item(CMD_IMAGE, 0, 0, 0, 0, 1234);
    send_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
    send_item(CMD_UNUSED, -1, -1, -1, -1, -1);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_register(REG_MIRROR, 32'(mirror_plan[p]));
      if (p == 3) write_register(REG_SPARE, $urandom);
      for (int k = 0; k < 180; k++) begin
        if (p == 5 && k >= 80) calm = 1'b1;
        send_random_item();
      end
      wait_drained();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/bru_pkg.sv
sv/bru_front.sv
sv/bru_cell.sv
sv/bru_back.sv
sv/bearing_and_range_unit.sv
test/tb_bearing_and_range_unit.sv
